/* rtl/rjt_pkg.sv */
// Shared types and constants for the relaxed JSON tokenizer.
// Used by the top level and the port checker; no dependencies.
package rjt_pkg;

	// Width of the saturating line counter (8 to 32)
	localparam int LINE_BITS = 16;

	// Result queue between the lexer stage and the token port
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	// Most results one text byte can give rise to
	localparam int MAX_RES    = 3;

	// Character codes
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef enum logic [1:0] {
		MODE_OUT     = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_QUOTED  = 2'd2,
		MODE_BARE    = 2'd3
	} lex_mode_t;

	typedef enum logic [2:0] {
		K_LOPEN  = 3'd0,
		K_LCLOSE = 3'd1,
		K_DOPEN  = 3'd2,
		K_DCLOSE = 3'd3,
		K_COLON  = 3'd4,
		K_BYTE   = 3'd5,
		K_VEND   = 3'd6,
		K_END    = 3'd7
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_end;
	} in_item_t;

	typedef struct packed {
		tok_kind_t   token_kind;
		logic [7:0]  value_byte;
		logic [15:0] line_number;
		logic        last;
	} out_item_t;

endpackage

/* rtl/relaxed_json_tokenizer.sv */
// Relaxed JSON tokenizer: one text byte per item, up to three tokens per item.
// Depends on rjt_pkg for types, character codes and queue sizing.
// Each item is held in the input register until its tokens enter the result queue.
// Throughput: 1 item per cycle while the 8-entry result queue has room for 3; the
// token port drains 1 token per cycle when not stalled, bounding multi-token bursts.
// Reset (arst_n low, asynchronous): outside mode, line count 1, queue empty.
module relaxed_json_tokenizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  rjt_pkg::in_item_t item,
	output logic              token_valid,
	input  logic              token_stall,
	output rjt_pkg::out_item_t token
);

	// Input register
	logic              valid_s1;
	rjt_pkg::in_item_t item_s1;

	// Lexer state
	rjt_pkg::lex_mode_t          mode_q, mode_d;
	logic                        qsingle_q, qsingle_d;
	logic                        esc_q, esc_d;
	logic [rjt_pkg::LINE_BITS-1:0] line_q, line_d;

	// Result queue
	rjt_pkg::out_item_t          fifo_q [rjt_pkg::FIFO_DEPTH];
	logic [rjt_pkg::PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [rjt_pkg::CNT_W-1:0]   count_q;

	// Results of the byte held in the input register
	rjt_pkg::out_item_t res [rjt_pkg::MAX_RES];
	logic [1:0]         res_n;

	logic room, fire, accept, pop;
	logic [7:0] b;
	logic is_ws, is_struct, is_quote, is_close_quote, do_out;
	rjt_pkg::tok_kind_t struct_kind;
	logic [31:0] line_ext;
	logic [15:0] line_out;

	// Handshakes
	assign room       = count_q <= rjt_pkg::CNT_W'(rjt_pkg::FIFO_DEPTH - rjt_pkg::MAX_RES);
	assign fire       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign accept     = item_valid && !item_stall;
	assign token_valid = count_q != '0;
	assign pop        = token_valid && !token_stall;
	assign token      = fifo_q[rd_ptr_q];

	// Byte classes
	assign b         = item_s1.in_byte;
	assign is_ws     = (b == rjt_pkg::CH_SPACE) || (b >= rjt_pkg::CH_TAB && b <= rjt_pkg::CH_CR);
	assign is_quote  = (b == rjt_pkg::CH_DQUOTE) || (b == rjt_pkg::CH_SQUOTE);
	assign is_close_quote = qsingle_q ? (b == rjt_pkg::CH_SQUOTE) : (b == rjt_pkg::CH_DQUOTE);

	always_comb begin
		is_struct   = 1'b1;
		struct_kind = rjt_pkg::K_LOPEN;
		unique case (b)
			rjt_pkg::CH_LBRK:   struct_kind = rjt_pkg::K_LOPEN;
			rjt_pkg::CH_RBRK:   struct_kind = rjt_pkg::K_LCLOSE;
			rjt_pkg::CH_LBRACE: struct_kind = rjt_pkg::K_DOPEN;
			rjt_pkg::CH_RBRACE: struct_kind = rjt_pkg::K_DCLOSE;
			rjt_pkg::CH_COLON:  struct_kind = rjt_pkg::K_COLON;
			default:            is_struct = 1'b0;
		endcase
	end

	// Byte is handled as outside a value (directly, or after closing a bare value)
	always_comb begin
		do_out = 1'b0;
		if (!item_s1.is_end) begin
			if (mode_q == rjt_pkg::MODE_OUT)
				do_out = 1'b1;
			else if (mode_q == rjt_pkg::MODE_BARE && !esc_q &&
			         (is_ws || b == rjt_pkg::CH_COMMA || is_struct))
				do_out = 1'b1;
		end
	end

	// Saturate the line count to the 16-bit field
	assign line_ext = 32'(line_q);
	assign line_out = (line_ext > 32'h0000_FFFF) ? 16'hFFFF : line_ext[15:0];

	// Next lexer state
	always_comb begin
		mode_d    = mode_q;
		qsingle_d = qsingle_q;
		esc_d     = esc_q;
		line_d    = line_q;
		if (item_s1.is_end) begin
			mode_d    = rjt_pkg::MODE_OUT;
			qsingle_d = 1'b0;
			esc_d     = 1'b0;
		end else begin
			unique case (mode_q)
				rjt_pkg::MODE_COMMENT: begin
					if (b == rjt_pkg::CH_LF) begin
						if (line_q != '1)
							line_d = line_q + 1'b1;
						mode_d = rjt_pkg::MODE_OUT;
					end
				end
				rjt_pkg::MODE_QUOTED: begin
					if (esc_q)
						esc_d = 1'b0;
					else if (b == rjt_pkg::CH_BSL)
						esc_d = 1'b1;
					else if (is_close_quote) begin
						mode_d    = rjt_pkg::MODE_OUT;
						qsingle_d = 1'b0;
					end
				end
				rjt_pkg::MODE_BARE: begin
					if (esc_q)
						esc_d = 1'b0;
					else if (do_out)
						mode_d = rjt_pkg::MODE_OUT;
					else if (b == rjt_pkg::CH_BSL)
						esc_d = 1'b1;
				end
				default: ;
			endcase
			if (do_out) begin
				if (b == rjt_pkg::CH_LF) begin
					if (line_q != '1)
						line_d = line_q + 1'b1;
				end else if (is_ws || b == rjt_pkg::CH_COMMA || is_struct) begin
					// skip, or structural token only
				end else if (b == rjt_pkg::CH_HASH) begin
					mode_d = rjt_pkg::MODE_COMMENT;
				end else if (is_quote) begin
					mode_d    = rjt_pkg::MODE_QUOTED;
					qsingle_d = (b == rjt_pkg::CH_SQUOTE);
					esc_d     = 1'b0;
				end else begin
					mode_d = rjt_pkg::MODE_BARE;
					esc_d  = (b == rjt_pkg::CH_BSL);
				end
			end
		end
	end

	// Results of the current byte
	always_comb begin
		res_n = 2'd0;
		for (int i = 0; i < rjt_pkg::MAX_RES; i++) begin
			res[i].token_kind  = rjt_pkg::K_END;
			res[i].value_byte  = 8'h00;
			res[i].line_number = line_out;
			res[i].last        = 1'b0;
		end
		if (item_s1.is_end) begin
			if (mode_q == rjt_pkg::MODE_QUOTED || mode_q == rjt_pkg::MODE_BARE) begin
				if (esc_q) begin
					res[res_n].token_kind = rjt_pkg::K_BYTE;
					res[res_n].value_byte = rjt_pkg::CH_BSL;
					res_n = res_n + 2'd1;
				end
				res[res_n].token_kind = rjt_pkg::K_VEND;
				res_n = res_n + 2'd1;
			end
			res[res_n].token_kind = rjt_pkg::K_END;
			res_n = res_n + 2'd1;
		end else begin
			if (mode_q == rjt_pkg::MODE_QUOTED || mode_q == rjt_pkg::MODE_BARE) begin
				if (esc_q) begin
					res[res_n].token_kind = rjt_pkg::K_BYTE;
					res[res_n].value_byte = b;
					res_n = res_n + 2'd1;
				end else if (mode_q == rjt_pkg::MODE_QUOTED) begin
					if (is_close_quote) begin
						res[res_n].token_kind = rjt_pkg::K_VEND;
						res_n = res_n + 2'd1;
					end else if (b != rjt_pkg::CH_BSL) begin
						res[res_n].token_kind = rjt_pkg::K_BYTE;
						res[res_n].value_byte = b;
						res_n = res_n + 2'd1;
					end
				end else if (do_out) begin
					res[res_n].token_kind = rjt_pkg::K_VEND;
					res_n = res_n + 2'd1;
				end else if (b != rjt_pkg::CH_BSL) begin
					res[res_n].token_kind = rjt_pkg::K_BYTE;
					res[res_n].value_byte = b;
					res_n = res_n + 2'd1;
				end
			end
			if (do_out) begin
				if (is_struct) begin
					res[res_n].token_kind = struct_kind;
					res_n = res_n + 2'd1;
				end else if (!is_ws && b != rjt_pkg::CH_COMMA && b != rjt_pkg::CH_HASH &&
				             !is_quote && b != rjt_pkg::CH_BSL) begin
					res[res_n].token_kind = rjt_pkg::K_BYTE;
					res[res_n].value_byte = b;
					res_n = res_n + 2'd1;
				end
			end
		end
		// Mark the final result of this byte
		for (int i = 0; i < rjt_pkg::MAX_RES; i++)
			res[i].last = (2'(i) + 2'd1 == res_n);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	// Lexer state, advanced when the held byte moves into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= rjt_pkg::MODE_OUT;
			qsingle_q <= 1'b0;
			esc_q     <= 1'b0;
			line_q    <= rjt_pkg::LINE_BITS'(1);
		end else if (fire) begin
			mode_q    <= mode_d;
			qsingle_q <= qsingle_d;
			esc_q     <= esc_d;
			line_q    <= line_d;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire)
				wr_ptr_q <= wr_ptr_q + rjt_pkg::PTR_W'(res_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (fire ? rjt_pkg::CNT_W'(res_n) : '0) -
			           rjt_pkg::CNT_W'(pop);
		end
	end

	// Write the results into free queue slots
	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < rjt_pkg::MAX_RES; i++) begin
				if (2'(i) < res_n)
					fifo_q[rjt_pkg::PTR_W'(wr_ptr_q + rjt_pkg::PTR_W'(i))] <= res[i];
			end
		end
	end

endmodule

/* rtl/rjt_checker.sv */
// Port checker for the relaxed JSON tokenizer, bound to the top level.
// Depends on rjt_pkg for the token kind codes and payload types.
module rjt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               token_valid,
	input logic               token_stall,
	input rjt_pkg::out_item_t token
);

	// Hold a stalled token
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid)
		else $error("token valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> $stable(token))
		else $error("token changed while stalled");

	// End token always closes its item's burst
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.token_kind == rjt_pkg::K_END |-> token.last)
		else $error("end token without last mark");

	// Only value bytes carry content
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.token_kind != rjt_pkg::K_BYTE |-> token.value_byte == 8'h00)
		else $error("non-byte token carries content");

	// Line count starts at one and never wraps to zero
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> token.line_number != 16'h0000)
		else $error("line number zero");

endmodule

bind relaxed_json_tokenizer rjt_checker u_rjt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token       (token)
);
